### design/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// shared types, register codes and fixed-point constants of the position
// controller
// ----------------------------------------------------------------------------
package pcp_pkg;

   // encoder counter width, count/period/zero are masked to it
   localparam int COUNT_WIDTH = 16;
   localparam logic [15:0] COUNT_MASK =
      (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_WIDTH) - 32'd1);

   // register indexes
   localparam logic [2:0] CSR_STORE_ANGLE    = 3'd0;
   localparam logic [2:0] CSR_RELEASE_OFFSET = 3'd1;
   localparam logic [2:0] CSR_INIT_OFFSET    = 3'd2;
   localparam logic [2:0] CSR_DRIVE_LIMIT    = 3'd3;
   localparam logic [2:0] CSR_ENCODER_PERIOD = 3'd4;
   localparam logic [2:0] CSR_ENCODER_ZERO   = 3'd5;
   localparam logic [2:0] CSR_PWM_TOP        = 3'd6;

   // modes
   localparam logic [1:0] CMD_STORE   = 2'd0;
   localparam logic [1:0] CMD_TRIGGER = 2'd1;
   localparam logic [1:0] CMD_INIT    = 2'd2;
   localparam logic [1:0] CMD_ZERO    = 2'd3;

   // counts to Q.4 degrees: round(pos*16000/97064) = floor((4000*pos+12133)/24266)
   localparam logic [11:0] DEG_GAIN = 12'd4000;
   localparam logic [14:0] DEG_DIV  = 15'd24266;
   localparam logic [13:0] DEG_HALF = 14'd12133;
   localparam longint unsigned DegRecipWide = ((64'd4000 << 32) + 64'd24265) / 64'd24266;
   localparam logic [29:0] DEG_RECIP = 30'(DegRecipWide);

   // remainder by 360 through a reciprocal, exact for 17-bit operands
   localparam logic [8:0]  MOD_BASE = 9'd360;
   localparam longint unsigned ModRecipWide = ((64'd1 << 26) + 64'd359) / 64'd360;
   localparam logic [17:0] MOD_RECIP = 18'(ModRecipWide);

   // degrees Q.4 to radians Q2.14: err*K/2^22
   localparam logic [26:0] RAD_K    = 27'd74961321;
   localparam logic [47:0] RAD_HALF = 48'd2097152;

   localparam logic signed [21:0] ERR_CLAMP = 22'sd1048576;
   localparam logic [14:0]        ONE_Q14   = 15'd16384;

   typedef struct packed {
      logic signed [19:0] store_angle;
      logic signed [19:0] release_offset;
      logic signed [19:0] init_offset;
      logic [14:0]        drive_limit;
      logic [15:0]        encoder_period;
      logic [15:0]        encoder_zero;
      logic [15:0]        pwm_top;
   } pcp_cfg_type;

   // angle error leaving the position stages
   typedef struct packed {
      logic               valid;
      logic [1:0]         cmd;
      logic signed [21:0] err;
   } pcp_err_type;

   // wrapped and clamped error entering the drive stages
   typedef struct packed {
      logic               valid;
      logic signed [21:0] err;
   } pcp_ctl_type;

endpackage

### design/position_p_controller_pwm_unit.sv
// ----------------------------------------------------------------------------
// position_p_controller_pwm_unit
// proportional position controller producing the two h-bridge compare values
// ----------------------------------------------------------------------------
// usage:
//   a control tick is issued by raising start with req_cmd and
//   req_encoder_count; it is taken at every rising edge where start is high
//   and busy is low. busy stays low, so one tick can be issued every cycle.
//   each tick yields one word on rsp_compare_a / rsp_compare_b, in issue
//   order: rsp_strobe rises for a single cycle once the tick has passed
//   all register stages, and the word is valid while it is high. the
//   thirteen register stages are five in pcp_angle, four in pcp_wrap and
//   four in pcp_drive; each multiply, the two reciprocal multiplies among
//   them, is followed by its own register.
//   the result side has no back-pressure: words must be taken when strobed.
//   registers are written through csr_we / csr_index / csr_wdata, one per
//   cycle with no wait; write them only with no tick in flight.
//   reset clears the pipeline valid bits and loads the register defaults
//   (zero angles, drive limit 1.0, full encoder period, pwm top 65535).
// ----------------------------------------------------------------------------
module position_p_controller_pwm_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_encoder_count,
   output logic        rsp_strobe,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import pcp_pkg::*;

   pcp_cfg_type cfg;
   pcp_err_type err_word;
   pcp_ctl_type ctl_word;
   logic        accept;

   // fully pipelined, never refuses a tick
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   pcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcp_angle u_angle (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (accept),
      .req_cmd           (req_cmd),
      .req_encoder_count (req_encoder_count),
      .cfg               (cfg),
      .err_out           (err_word)
   );

   pcp_wrap u_wrap (
      .clock   (clock),
      .reset   (reset),
      .err_in  (err_word),
      .ctl_out (ctl_word)
   );

   pcp_drive u_drive (
      .clock         (clock),
      .reset         (reset),
      .ctl_in        (ctl_word),
      .cfg           (cfg),
      .rsp_strobe    (rsp_strobe),
      .rsp_compare_a (rsp_compare_a),
      .rsp_compare_b (rsp_compare_b)
   );

endmodule

### design/pcp_csr.sv
// ----------------------------------------------------------------------------
// pcp_csr
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module pcp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_wdata,
   output pcp_pkg::pcp_cfg_type cfg
);
   import pcp_pkg::*;

   pcp_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STORE_ANGLE:    cfg_in.store_angle    = $signed(csr_wdata);
            CSR_RELEASE_OFFSET: cfg_in.release_offset = $signed(csr_wdata);
            CSR_INIT_OFFSET:    cfg_in.init_offset    = $signed(csr_wdata);
            CSR_DRIVE_LIMIT:    cfg_in.drive_limit    = csr_wdata[14:0];
            CSR_ENCODER_PERIOD: cfg_in.encoder_period = csr_wdata[15:0];
            CSR_ENCODER_ZERO:   cfg_in.encoder_zero   = csr_wdata[15:0];
            CSR_PWM_TOP:        cfg_in.pwm_top        = csr_wdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.store_angle    <= '0;
         cfg_ff.release_offset <= '0;
         cfg_ff.init_offset    <= '0;
         cfg_ff.drive_limit    <= ONE_Q14;
         cfg_ff.encoder_period <= 16'hFFFF;
         cfg_ff.encoder_zero   <= '0;
         cfg_ff.pwm_top        <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/pcp_angle.sv
// ----------------------------------------------------------------------------
// pcp_angle
// five stages: shaft position, scaling to Q.4 degrees, target selection and
// angle error
// ----------------------------------------------------------------------------
module pcp_angle (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0]           req_cmd,
   input  logic [15:0]          req_encoder_count,
   input  pcp_pkg::pcp_cfg_type cfg,
   output pcp_pkg::pcp_err_type err_out
);
   import pcp_pkg::*;

   // stage 1: position and target
   logic [15:0]        count_m, period_m, zero_m;
   logic signed [17:0] pos_raw, period_s, s1_pos_in, s1_pos_ff;
   logic signed [21:0] store_s, release_s, init_s, s1_tgt_in, s1_tgt_ff;
   logic [1:0]         s1_cmd_ff;
   logic               s1_valid_ff;

   always_comb begin
      count_m   = req_encoder_count & COUNT_MASK;
      period_m  = cfg.encoder_period & COUNT_MASK;
      zero_m    = cfg.encoder_zero & COUNT_MASK;
      period_s  = $signed({2'b00, period_m});
      pos_raw   = $signed({2'b00, count_m}) + period_s - $signed({2'b00, zero_m});
      // single conditional wrap, position may stay out of range
      s1_pos_in = (pos_raw >= period_s) ? pos_raw - period_s : pos_raw;
      store_s   = $signed({{2{cfg.store_angle[19]}}, cfg.store_angle});
      release_s = $signed({{2{cfg.release_offset[19]}}, cfg.release_offset});
      init_s    = $signed({{2{cfg.init_offset[19]}}, cfg.init_offset});
      case (req_cmd)
         CMD_STORE:   s1_tgt_in = store_s;
         CMD_TRIGGER: s1_tgt_in = store_s + release_s;
         CMD_INIT:    s1_tgt_in = store_s + release_s + init_s;
         default:     s1_tgt_in = '0;
      endcase
   end

   // stage 2: magnitude times reciprocal gives the quotient estimate
   logic signed [17:0] pos_neg;
   logic [15:0]        s2_mag_in, s2_mag_ff;
   logic [45:0]        deg_prod;
   logic [13:0]        s2_q0_ff;
   logic               s2_neg_ff, s2_valid_ff;
   logic [1:0]         s2_cmd_ff;
   logic signed [21:0] s2_tgt_ff;

   always_comb begin
      pos_neg   = -s1_pos_ff;
      s2_mag_in = s1_pos_ff[17] ? pos_neg[15:0] : s1_pos_ff[15:0];
      deg_prod  = {30'd0, s2_mag_in} * {16'd0, DEG_RECIP};
   end

   // stage 3: back-multiply and rounding numerator
   logic [28:0]        s3_qd_in, s3_qd_ff;
   logic [27:0]        s3_num_in, s3_num_ff;
   logic [13:0]        s3_q0_ff;
   logic               s3_neg_ff, s3_valid_ff;
   logic [1:0]         s3_cmd_ff;
   logic signed [21:0] s3_tgt_ff;

   always_comb begin
      s3_qd_in  = {15'd0, s2_q0_ff} * {14'd0, DEG_DIV};
      s3_num_in = {12'd0, s2_mag_ff} * {16'd0, DEG_GAIN} + {14'd0, DEG_HALF};
   end

   // stage 4: estimate is low by at most one
   logic [28:0]        rem;
   logic [13:0]        s4_q_in, s4_q_ff;
   logic               s4_neg_ff, s4_valid_ff;
   logic [1:0]         s4_cmd_ff;
   logic signed [21:0] s4_tgt_ff;

   always_comb begin
      rem     = {1'b0, s3_num_ff} - s3_qd_ff;
      s4_q_in = s3_q0_ff + {13'd0, (rem >= {14'd0, DEG_DIV})};
   end

   // stage 5: signed angle and error
   logic signed [14:0] q_s, theta;
   logic signed [21:0] s5_err_in, s5_err_ff;
   logic [1:0]         s5_cmd_ff;
   logic               s5_valid_ff;

   always_comb begin
      q_s       = $signed({1'b0, s4_q_ff});
      theta     = s4_neg_ff ? -q_s : q_s;
      s5_err_in = s4_tgt_ff - $signed({{7{theta[14]}}, theta});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
      s1_tgt_ff <= s1_tgt_in;
      s1_cmd_ff <= req_cmd;

      s2_mag_ff <= s2_mag_in;
      s2_q0_ff  <= deg_prod[45:32];
      s2_neg_ff <= s1_pos_ff[17];
      s2_cmd_ff <= s1_cmd_ff;
      s2_tgt_ff <= s1_tgt_ff;

      s3_qd_ff  <= s3_qd_in;
      s3_num_ff <= s3_num_in;
      s3_q0_ff  <= s2_q0_ff;
      s3_neg_ff <= s2_neg_ff;
      s3_cmd_ff <= s2_cmd_ff;
      s3_tgt_ff <= s2_tgt_ff;

      s4_q_ff   <= s4_q_in;
      s4_neg_ff <= s3_neg_ff;
      s4_cmd_ff <= s3_cmd_ff;
      s4_tgt_ff <= s3_tgt_ff;

      s5_err_ff <= s5_err_in;
      s5_cmd_ff <= s4_cmd_ff;
   end

   assign err_out.valid = s5_valid_ff;
   assign err_out.cmd   = s5_cmd_ff;
   assign err_out.err   = s5_err_ff;

endmodule

### design/pcp_wrap.sv
// ----------------------------------------------------------------------------
// pcp_wrap
// four stages: init-mode wrap of the error to whole degrees rem 360, and the
// wide clamp of the error
// ----------------------------------------------------------------------------
module pcp_wrap (
   input  logic                 clock,
   input  logic                 reset,
   input  pcp_pkg::pcp_err_type err_in,
   output pcp_pkg::pcp_ctl_type ctl_out
);
   import pcp_pkg::*;

   // stage 6: whole degrees, truncated toward zero on the magnitude
   logic signed [21:0] err_neg, abs_err;
   logic [16:0]        s6_deg_ff;
   logic               s6_neg_ff, s6_valid_ff;
   logic [1:0]         s6_cmd_ff;
   logic signed [21:0] s6_err_ff;

   always_comb begin
      err_neg = -err_in.err;
      abs_err = err_in.err[21] ? err_neg : err_in.err;
   end

   // stage 7: quotient by 360
   logic [34:0]        mod_prod;
   logic [8:0]         s7_q_ff;
   logic [16:0]        s7_deg_ff;
   logic               s7_neg_ff, s7_valid_ff;
   logic [1:0]         s7_cmd_ff;
   logic signed [21:0] s7_err_ff;

   assign mod_prod = {18'd0, s6_deg_ff} * {17'd0, MOD_RECIP};

   // stage 8: remainder
   logic [16:0]        rem_full;
   logic [8:0]         s8_rem_ff;
   logic               s8_neg_ff, s8_valid_ff;
   logic [1:0]         s8_cmd_ff;
   logic signed [21:0] s8_err_ff;

   assign rem_full = s7_deg_ff - {8'd0, s7_q_ff} * {8'd0, MOD_BASE};

   // stage 9: remainder takes the sign of the error, else clamp
   logic signed [21:0] wrap_pos, s9_err_in, s9_err_ff;
   logic               s9_valid_ff;

   always_comb begin
      wrap_pos = $signed({9'd0, s8_rem_ff, 4'd0});
      if (s8_cmd_ff == CMD_INIT) begin
         s9_err_in = s8_neg_ff ? -wrap_pos : wrap_pos;
      end else if (s8_err_ff > ERR_CLAMP) begin
         s9_err_in = ERR_CLAMP;
      end else if (s8_err_ff < -ERR_CLAMP) begin
         s9_err_in = -ERR_CLAMP;
      end else begin
         s9_err_in = s8_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= err_in.valid;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_deg_ff <= abs_err[20:4];
      s6_neg_ff <= err_in.err[21];
      s6_cmd_ff <= err_in.cmd;
      s6_err_ff <= err_in.err;

      s7_q_ff   <= mod_prod[34:26];
      s7_deg_ff <= s6_deg_ff;
      s7_neg_ff <= s6_neg_ff;
      s7_cmd_ff <= s6_cmd_ff;
      s7_err_ff <= s6_err_ff;

      s8_rem_ff <= rem_full[8:0];
      s8_neg_ff <= s7_neg_ff;
      s8_cmd_ff <= s7_cmd_ff;
      s8_err_ff <= s7_err_ff;

      s9_err_ff <= s9_err_in;
   end

   assign ctl_out.valid = s9_valid_ff;
   assign ctl_out.err   = s9_err_ff;

endmodule

### design/pcp_drive.sv
// ----------------------------------------------------------------------------
// pcp_drive
// four stages: error to radians, limit, scaling to the PWM range and the two
// bridge compare values
// ----------------------------------------------------------------------------
module pcp_drive (
   input  logic                 clock,
   input  logic                 reset,
   input  pcp_pkg::pcp_ctl_type ctl_in,
   input  pcp_pkg::pcp_cfg_type cfg,
   output logic                 rsp_strobe,
   output logic [15:0]          rsp_compare_a,
   output logic [15:0]          rsp_compare_b
);
   import pcp_pkg::*;

   // stage 10: magnitude times degrees-to-radians gain
   logic signed [21:0] err_neg;
   logic [20:0]        err_mag;
   logic [47:0]        s10_prod_in, s10_prod_ff;
   logic               s10_neg_ff, s10_valid_ff;

   always_comb begin
      err_neg     = -ctl_in.err;
      err_mag     = ctl_in.err[21] ? err_neg[20:0] : ctl_in.err[20:0];
      s10_prod_in = {27'd0, err_mag} * {21'd0, RAD_K};
   end

   // stage 11: round half away from zero, then limit
   logic [47:0] rad_sum;
   logic [25:0] rad_mag;
   logic [14:0] lim, s11_rad_in, s11_rad_ff;
   logic        s11_neg_ff, s11_valid_ff;

   always_comb begin
      rad_sum    = s10_prod_ff + RAD_HALF;
      rad_mag    = rad_sum[47:22];
      lim        = (cfg.drive_limit > ONE_Q14) ? ONE_Q14 : cfg.drive_limit;
      s11_rad_in = (rad_mag > {11'd0, lim}) ? lim : rad_mag[14:0];
   end

   // stage 12: drive in timer counts
   logic [30:0] drv_prod;
   logic [15:0] s12_drive_ff;
   logic        s12_neg_ff, s12_nz_ff, s12_valid_ff;

   assign drv_prod = {15'd0, cfg.pwm_top} * {16'd0, s11_rad_ff};

   // stage 13: output word
   logic [15:0] comp_a_in, comp_b_in, comp_a_ff, comp_b_ff;
   logic [15:0] top_minus;
   logic        strobe_ff;

   always_comb begin
      top_minus = cfg.pwm_top - s12_drive_ff;
      comp_a_in = (s12_nz_ff && !s12_neg_ff) ? top_minus : cfg.pwm_top;
      comp_b_in = (s12_nz_ff && s12_neg_ff) ? top_minus : cfg.pwm_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         s10_valid_ff <= ctl_in.valid;
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
         strobe_ff    <= s12_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s10_prod_ff  <= s10_prod_in;
      s10_neg_ff   <= ctl_in.err[21];

      s11_rad_ff   <= s11_rad_in;
      s11_neg_ff   <= s10_neg_ff;

      s12_drive_ff <= drv_prod[29:14];
      s12_neg_ff   <= s11_neg_ff;
      s12_nz_ff    <= (s11_rad_ff != 15'd0);

      comp_a_ff    <= comp_a_in;
      comp_b_ff    <= comp_b_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_compare_a = comp_a_ff;
   assign rsp_compare_b = comp_b_ff;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression for position_p_controller_pwm_unit: ticks are issued through the
// start/busy port and every compare word is checked against a local model of
// the position-to-pwm arithmetic, over reset defaults, register corner values
// and randomized settings with varying sender idle rates
// ----------------------------------------------------------------------------
module tb;
   import pcp_pkg::*;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          PRINT_CAP     = 50;
   localparam int          SEG_TICKS     = 95;
   localparam longint      DEG_SCALE_NUM = 16000;
   localparam longint      DEG_SCALE_DEN = 97064;
   localparam longint      DEG2RAD_K     = 74961321;
   localparam longint      ERR_LIMIT     = 1048576;
   localparam longint      UNITY_Q14     = 16384;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
   } compare_pair_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [15:0] req_encoder_count;
   logic        rsp_strobe;
   logic [15:0] rsp_compare_a;
   logic [15:0] rsp_compare_b;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [19:0] csr_wdata;

   pcp_cfg_type      shadow_cfg;
   compare_pair_type pending_compare[$];
   int unsigned      sender_idle_pct;
   int unsigned      ticks_sent;
   int unsigned      words_checked;
   int unsigned      settings_applied;
   int unsigned      mismatch_count;
   int unsigned      cycle_count;

   position_p_controller_pwm_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_encoder_count (req_encoder_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_compare_a     (rsp_compare_a),
      .rsp_compare_b     (rsp_compare_b),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("position_p_controller_pwm_unit regression: fail");
         $finish;
      end
   end

   // rounding division, ties away from zero
   function automatic longint round_div(longint num, longint den);
      if (num >= 0)
         return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic compare_pair_type predict_compare(logic [1:0] cmd, logic [15:0] count);
      longint           cnt, per, zer, pos, theta, target, err, rad, lim;
      longint           sa, ro, io;
      longint unsigned  top, drive;
      compare_pair_type res;
      cnt = count & COUNT_MASK;
      per = shadow_cfg.encoder_period & COUNT_MASK;
      zer = shadow_cfg.encoder_zero & COUNT_MASK;
      sa  = shadow_cfg.store_angle;
      ro  = shadow_cfg.release_offset;
      io  = shadow_cfg.init_offset;
      top = shadow_cfg.pwm_top;
      // single conditional wrap, position may stay out of range
      pos = cnt + per - zer;
      if (pos >= per)
         pos = pos - per;
      theta = round_div(pos * DEG_SCALE_NUM, DEG_SCALE_DEN);
      case (cmd)
         CMD_STORE:   target = sa;
         CMD_TRIGGER: target = sa + ro;
         CMD_INIT:    target = sa + ro + io;
         default:     target = 0;
      endcase
      err = target - theta;
      // whole degrees, remainder keeps the dividend sign
      if (cmd == CMD_INIT)
         err = ((err / 16) % 360) * 16;
      if (err > ERR_LIMIT)
         err = ERR_LIMIT;
      else if (err < -ERR_LIMIT)
         err = -ERR_LIMIT;
      rad = round_div(err * DEG2RAD_K, longint'(1) << 22);
      lim = (shadow_cfg.drive_limit > UNITY_Q14) ? UNITY_Q14 : longint'(shadow_cfg.drive_limit);
      if (rad > lim)
         rad = lim;
      else if (rad < -lim)
         rad = -lim;
      res.a = top[15:0];
      res.b = top[15:0];
      if (rad > 0) begin
         drive = (top * longint'(rad)) >> 14;
         res.a = 16'(top - drive);
      end else if (rad < 0) begin
         drive = (top * longint'(-rad)) >> 14;
         res.b = 16'(top - drive);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %0d want %0d",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_words
      compare_pair_type want;
      if (!reset && rsp_strobe) begin
         if (pending_compare.size() == 0) begin
            report_mismatch("word with none pending, compare_a", rsp_compare_a, 16'd0);
         end else begin
            want = pending_compare.pop_front();
            if (rsp_compare_a !== want.a)
               report_mismatch("compare_a", rsp_compare_a, want.a);
            if (rsp_compare_b !== want.b)
               report_mismatch("compare_b", rsp_compare_b, want.b);
            words_checked++;
         end
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [19:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      case (index)
         CSR_STORE_ANGLE:    shadow_cfg.store_angle    = data;
         CSR_RELEASE_OFFSET: shadow_cfg.release_offset = data;
         CSR_INIT_OFFSET:    shadow_cfg.init_offset    = data;
         CSR_DRIVE_LIMIT:    shadow_cfg.drive_limit    = data[14:0];
         CSR_ENCODER_PERIOD: shadow_cfg.encoder_period = data[15:0];
         CSR_ENCODER_ZERO:   shadow_cfg.encoder_zero   = data[15:0];
         CSR_PWM_TOP:        shadow_cfg.pwm_top        = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_setting(input logic [19:0] store, input logic [19:0] rel,
                                input logic [19:0] init, input logic [19:0] limit,
                                input logic [19:0] period, input logic [19:0] zero,
                                input logic [19:0] top);
      write_reg(CSR_STORE_ANGLE, store);
      write_reg(CSR_RELEASE_OFFSET, rel);
      write_reg(CSR_INIT_OFFSET, init);
      write_reg(CSR_DRIVE_LIMIT, limit);
      write_reg(CSR_ENCODER_PERIOD, period);
      write_reg(CSR_ENCODER_ZERO, zero);
      write_reg(CSR_PWM_TOP, top);
      settings_applied++;
   endtask

   task automatic send_tick(input logic [1:0] cmd, input logic [15:0] count);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start             = 1'b1;
      req_cmd           = cmd;
      req_encoder_count = count;
      do
         @(posedge clock);
      while (busy);
      pending_compare.push_back(predict_compare(cmd, count));
      ticks_sent++;
   endtask

   task automatic wait_all_words();
      @(negedge clock);
      start = 1'b0;
      while (pending_compare.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      sender_idle_pct = 0;
      send_tick(CMD_STORE, 16'd0);
      send_tick(CMD_STORE, 16'hFFFF);
      send_tick(CMD_STORE, 16'd1);
      send_tick(CMD_TRIGGER, 16'h8000);
      send_tick(CMD_INIT, 16'hFFFE);
      send_tick(CMD_ZERO, 16'h5555);
      send_tick(CMD_ZERO, 16'hAAAA);
      wait_all_words();
   endtask

   task automatic test_register_corners();
      sender_idle_pct = 0;
      // period zero, zero above count, drive limit above one
      write_setting(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h07FFF, 20'd0, 20'hFFFF, 20'hFFFF);
      send_tick(CMD_STORE, 16'd0);
      send_tick(CMD_TRIGGER, 16'hFFFF);
      send_tick(CMD_INIT, 16'd0);
      send_tick(CMD_INIT, 16'hFFFF);
      send_tick(CMD_ZERO, 16'd0);
      wait_all_words();
      // period one keeps counts above the period, zero drive and top
      write_setting(20'h80000, 20'd0, 20'd0, 20'd0, 20'd1, 20'd0, 20'd0);
      send_tick(CMD_STORE, 16'd0);
      send_tick(CMD_STORE, 16'hFFFF);
      send_tick(CMD_INIT, 16'd1);
      send_tick(CMD_ZERO, 16'd2);
      wait_all_words();
      // unsaturated drive and negative init wrap
      write_setting(20'd800, 20'(-200), 20'(-6000), 20'd16384, 20'hFFFF, 20'd100, 20'd1000);
      send_tick(CMD_STORE, 16'd100);
      send_tick(CMD_TRIGGER, 16'd100);
      send_tick(CMD_INIT, 16'd100);
      send_tick(CMD_INIT, 16'd50);
      send_tick(CMD_ZERO, 16'd101);
      wait_all_words();
   endtask

   function automatic logic [19:0] pick_angle(input int unsigned span);
      case ($urandom_range(7))
         0:       return 20'h80000;
         1:       return 20'h7FFFF;
         2:       return 20'($urandom);
         default: return 20'(int'($urandom_range(span)) - int'(span / 4));
      endcase
   endfunction

   task automatic apply_random_setting();
      logic [19:0] limit, period, zero, top;
      case ($urandom_range(5))
         0:       limit = 20'd0;
         1:       limit = 20'd16384;
         2:       limit = 20'($urandom_range(32767, 16385));
         default: limit = 20'($urandom_range(16384));
      endcase
      case ($urandom_range(9))
         0:       period = 20'd0;
         1:       period = 20'd1;
         2:       period = 20'hFFFF;
         3:       period = 20'($urandom_range(64, 2));
         default: period = 20'($urandom_range(65535, 1));
      endcase
      if (period != 0 && $urandom_range(5) != 0)
         zero = 20'($urandom_range(period - 1));
      else
         zero = 20'($urandom_range(65535));
      case ($urandom_range(5))
         0:       top = 20'd0;
         1:       top = 20'hFFFF;
         default: top = 20'($urandom_range(65535));
      endcase
      write_setting(pick_angle(15000), pick_angle(6000), pick_angle(6000),
                    limit, period, zero, top);
   endtask

   // count whose angle lands near the store target, so the drive stays unsaturated
   function automatic logic [15:0] count_near_store();
      longint pos, raw, per;
      pos = (longint'(shadow_cfg.store_angle) * DEG_SCALE_DEN) / DEG_SCALE_NUM
            + (int'($urandom_range(300)) - 150);
      raw = pos + longint'(shadow_cfg.encoder_zero);
      per = shadow_cfg.encoder_period;
      if (per != 0)
         raw = ((raw % per) + per) % per;
      return raw[15:0];
   endfunction

   task automatic test_random_ticks();
      int unsigned idle_levels[3] = '{0, 82, 25};
      logic [1:0]  cmd;
      logic [15:0] count;
      int unsigned pick;
      foreach (idle_levels[lvl]) begin
         for (int seg = 0; seg < 3; seg++) begin
            apply_random_setting();
            sender_idle_pct = idle_levels[lvl];
            for (int i = 0; i < SEG_TICKS; i++) begin
               cmd  = 2'($urandom_range(3));
               pick = $urandom_range(99);
               if (pick < 15)
                  count = 16'($urandom);
               else if (pick < 45 || shadow_cfg.encoder_period == 0)
                  count = count_near_store();
               else
                  count = 16'($urandom_range(shadow_cfg.encoder_period - 1));
               send_tick(cmd, count);
               // let the pipeline run dry midway through each setting
               if (i == SEG_TICKS / 2)
                  wait_all_words();
            end
            wait_all_words();
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_cmd           = CMD_STORE;
      req_encoder_count = 16'd0;
      csr_we            = 1'b0;
      csr_index         = CSR_STORE_ANGLE;
      csr_wdata         = 20'd0;
      sender_idle_pct   = 0;
      ticks_sent        = 0;
      words_checked     = 0;
      settings_applied  = 0;
      mismatch_count    = 0;
      cycle_count       = 0;
      shadow_cfg        = '{store_angle: 20'sd0, release_offset: 20'sd0, init_offset: 20'sd0,
                            drive_limit: 15'd16384, encoder_period: 16'hFFFF,
                            encoder_zero: 16'd0, pwm_top: 16'hFFFF};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_register_corners();
      test_random_ticks();

      $display("covered %0d control ticks in all four modes over %0d register settings",
               ticks_sent, settings_applied);
      $display("checked %0d compare words, %0d field mismatches", words_checked,
               mismatch_count);
      if (mismatch_count == 0 && pending_compare.size() == 0)
         $display("position_p_controller_pwm_unit regression: pass");
      else
         $display("position_p_controller_pwm_unit regression: fail");
      $finish;
   end

endmodule
